// ----- sv/dscs_pkg.sv -----
// Package for the dual-slot checked config store: payload structs, record
// layout, FNV constants and the sequencer state type. No dependencies.
`default_nettype none
package dscs_pkg;

  localparam logic [31:0] MAGIC_WORD = 32'h4D47_3234;
  localparam logic [31:0] FNV_BASIS  = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME  = 32'd16777619;
  localparam logic [31:0] CHECK_FLIP = 32'hFFFF_FFFF;
  localparam logic [15:0] SCHEMA     = 16'd1;
  localparam int unsigned REC_BYTES  = 32;
  localparam int unsigned SLOT_DEPTH = 2;
  // stored row: record body plus checksum
  localparam int unsigned REC_W      = 32 * 5 + 8 * 4 + 16;
  localparam int unsigned ROW_W      = REC_W + 32;

  localparam logic [31:0] MIN_WRITE_INTERVAL_RST = 32'd0;
  localparam logic [7:0]  MAX_FILTER_KIND_RST    = 8'd3;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_LOAD  = 2'd1,
    OP_INV0  = 2'd2,
    OP_INV1  = 2'd3
  } op_t;

  localparam logic [0:0] REG_MIN_INTERVAL = 1'd0;
  localparam logic [0:0] REG_MAX_KIND     = 1'd1;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] sample_interval;
    logic [31:0] processing_interval;
    logic [31:0] report_interval;
    logic [31:0] heartbeat_interval;
    logic [7:0]  filter_kind;
    logic [7:0]  filter_size;
    logic [7:0]  enable_flag;
    logic [15:0] spare_half;
    logic [7:0]  spare_byte;
    logic [31:0] now_ms;
    logic        force_write;
  } in_item_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] out_generation;
    logic [31:0] out_sample_interval;
    logic [31:0] out_processing_interval;
    logic [31:0] out_report_interval;
    logic [31:0] out_heartbeat_interval;
    logic [7:0]  out_filter_kind;
    logic [7:0]  out_filter_size;
    logic [7:0]  out_enable_flag;
    logic [15:0] out_spare_half;
    logic [7:0]  out_spare_byte;
  } out_item_t;

  typedef struct packed {
    logic [31:0] gen;
    logic [31:0] smp;
    logic [31:0] prc;
    logic [31:0] rep;
    logic [31:0] hb;
    logic [7:0]  kind;
    logic [7:0]  size;
    logic [7:0]  en;
    logic [15:0] sh;
    logic [7:0]  sb;
  } rec_t;

  typedef struct packed {
    rec_t        rec;
    logic [31:0] check;
  } row_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_HASH,
    ST_NEXT,
    ST_WR,
    ST_DONE
  } state_t;

  // byte i of the 32-byte little-endian hashed layout
  function automatic logic [7:0] rec_byte(rec_t r, logic [4:0] i);
    logic [255:0] flat;
    flat = {r.sb, r.en, r.size, r.kind, r.hb, r.rep, r.prc, r.smp, r.gen,
            r.sh, SCHEMA, MAGIC_WORD};
    return flat[{i, 3'b000} +: 8];
  endfunction

  function automatic logic ranges_ok(rec_t r, logic [7:0] max_kind);
    return (r.en <= 8'd1) &&
           (r.smp >= 32'd10) && (r.smp <= 32'd5000) &&
           (r.prc >= 32'd10) && (r.prc <= 32'd5000) &&
           (r.rep >= 32'd50) && (r.rep <= 32'd5000) &&
           (r.hb >= 32'd1000) && (r.hb <= 32'd3600000) &&
           (r.kind <= max_kind) &&
           (r.size >= 8'd1) && (r.size <= 8'd9);
  endfunction

endpackage
`default_nettype wire

// ----- sv/dual_slot_checked_config_store.sv -----
// Top level of the dual-slot checked config store.
// Depends on dscs_pkg and dscs_ram.
//
// Two A/B slots of one channel configuration record, each held in a slot RAM
// row together with its FNV-1a-32 checksum. One item is handled at a time.
// A write hashes its 32 bytes, one byte per cycle through a 32x32 multiply,
// then writes the row; a refused or out-of-range write goes straight to its
// result; a load reads each slot from the RAM and re-hashes it; an invert op
// reads the row, flips its checksum and writes it back. The result sits in an
// output register, so the next item may be taken as soon as that register is
// handed off. Slot filled bits, newest slot, last write time and write count
// live in flip-flops; the contents of a row whose filled bit is clear are
// never used, so the RAM needs no clearing.
`default_nettype none
module dual_slot_checked_config_store (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire dscs_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output dscs_pkg::out_item_t     out_data,
  input  wire logic               cfg_we,
  input  wire logic [0:0]         cfg_index,
  input  wire logic [31:0]        cfg_wdata
);
  localparam int unsigned SLOTS = dscs_pkg::SLOT_DEPTH;
  localparam int unsigned AW    = $clog2(SLOTS);

  dscs_pkg::state_t state_r, state_nxt;

  // configuration
  logic [31:0] min_int_r;
  logic [7:0]  max_kind_r;

  // persistent control state
  logic [SLOTS-1:0] filled_r;
  logic [AW-1:0]    newest_r;
  logic [31:0]      last_time_r;
  logic [31:0]      writes_r;

  // per-item working registers
  dscs_pkg::in_item_t item_r;
  dscs_pkg::rec_t     rec_r;       // record being hashed
  logic [31:0]        stored_chk_r;
  logic [31:0]        hash_r;
  logic [5:0]         cnt_r;       // byte counter, 0..REC_BYTES
  logic [AW-1:0]      slot_r;      // slot under work
  logic               pass_r;      // load: second slot pass
  logic               v0_r;
  dscs_pkg::rec_t     rec0_r;

  dscs_pkg::out_item_t out_r;
  logic                out_valid_r;

  // RAM port
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  dscs_pkg::row_t ram_wdata, ram_rdata;

  dscs_ram #(.WIDTH(dscs_pkg::ROW_W), .DEPTH(SLOTS)) u_slots (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  logic accept;
  assign in_stall  = (state_r != dscs_pkg::ST_IDLE) || (out_valid_r && out_stall);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // write gating computed straight from the accepted item
  logic wr_refused;
  assign wr_refused = !in_data.force_write && (writes_r != 32'd0) &&
                      ((in_data.now_ms - last_time_r) < min_int_r);

  dscs_pkg::rec_t in_rec;
  always_comb begin
    in_rec.gen  = writes_r + 32'd1;
    in_rec.smp  = in_data.sample_interval;
    in_rec.prc  = in_data.processing_interval;
    in_rec.rep  = in_data.report_interval;
    in_rec.hb   = in_data.heartbeat_interval;
    in_rec.kind = in_data.filter_kind;
    in_rec.size = in_data.filter_size;
    in_rec.en   = in_data.enable_flag;
    in_rec.sh   = in_data.spare_half;
    in_rec.sb   = in_data.spare_byte;
  end

  logic wr_ok;
  assign wr_ok = !(wr_refused || !dscs_pkg::ranges_ok(in_rec, max_kind_r));

  // result register contents at acceptance: only a stored write reports ok here
  dscs_pkg::out_item_t out_init;
  always_comb begin
    out_init    = '0;
    out_init.ok = (dscs_pkg::op_t'(in_data.opcode) == dscs_pkg::OP_WRITE) && wr_ok;
  end

  logic [AW-1:0] wr_target;
  assign wr_target = filled_r[newest_r] ? ~newest_r : newest_r;

  logic hash_done;
  assign hash_done = (cnt_r == 6'(dscs_pkg::REC_BYTES));

  logic slot_good;
  assign slot_good = filled_r[slot_r] && (stored_chk_r == hash_r) &&
                     dscs_pkg::ranges_ok(rec_r, max_kind_r);

  logic [31:0] hash_step;
  assign hash_step = (hash_r ^ {24'd0, dscs_pkg::rec_byte(rec_r, cnt_r[4:0])})
                     * dscs_pkg::FNV_PRIME;

  dscs_pkg::op_t op;
  assign op = dscs_pkg::op_t'(item_r.opcode);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dscs_pkg::ST_IDLE: begin
        if (accept) begin
          if (dscs_pkg::op_t'(in_data.opcode) == dscs_pkg::OP_WRITE) begin
            if (!wr_ok) begin
              state_nxt = dscs_pkg::ST_DONE;
            end else begin
              state_nxt = dscs_pkg::ST_HASH;
            end
          end else begin
            state_nxt = dscs_pkg::ST_RD;
          end
        end
      end
      dscs_pkg::ST_RD:   state_nxt = (op == dscs_pkg::OP_LOAD) ? dscs_pkg::ST_HASH
                                                            : dscs_pkg::ST_WR;
      dscs_pkg::ST_HASH: if (hash_done) begin
        state_nxt = (op == dscs_pkg::OP_LOAD) ? dscs_pkg::ST_NEXT : dscs_pkg::ST_WR;
      end
      dscs_pkg::ST_NEXT: state_nxt = pass_r ? dscs_pkg::ST_DONE : dscs_pkg::ST_RD;
      dscs_pkg::ST_WR:   state_nxt = dscs_pkg::ST_DONE;
      dscs_pkg::ST_DONE: state_nxt = dscs_pkg::ST_IDLE;
      default:           state_nxt = dscs_pkg::ST_IDLE;
    endcase
  end

  // RAM port drive
  always_comb begin
    ram_we          = 1'b0;
    ram_addr        = slot_r;
    ram_wdata.rec   = rec_r;
    ram_wdata.check = hash_r;
    unique case (state_r)
      dscs_pkg::ST_WR: begin
        // invert ops only touch a filled slot
        ram_we = (op == dscs_pkg::OP_WRITE) || filled_r[slot_r];
        if (op != dscs_pkg::OP_WRITE) begin
          // invert: write back the row just read with its checksum flipped
          ram_wdata.rec   = ram_rdata.rec;
          ram_wdata.check = ram_rdata.check ^ dscs_pkg::CHECK_FLIP;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dscs_pkg::ST_IDLE;
      min_int_r   <= dscs_pkg::MIN_WRITE_INTERVAL_RST;
      max_kind_r  <= dscs_pkg::MAX_FILTER_KIND_RST;
      filled_r    <= '0;
      newest_r    <= '0;
      last_time_r <= '0;
      writes_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          dscs_pkg::REG_MIN_INTERVAL: min_int_r  <= cfg_wdata;
          dscs_pkg::REG_MAX_KIND:     max_kind_r <= cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == dscs_pkg::ST_WR) begin
        if (op == dscs_pkg::OP_WRITE) begin
          // commit the new record
          filled_r[slot_r] <= 1'b1;
          newest_r         <= slot_r;
          last_time_r      <= item_r.now_ms;
          writes_r         <= writes_r + 32'd1;
        end
      end
      if (state_r == dscs_pkg::ST_DONE) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      dscs_pkg::ST_IDLE: begin
        if (accept) begin
          item_r <= in_data;
          rec_r  <= in_rec;
          hash_r <= dscs_pkg::FNV_BASIS;
          cnt_r  <= '0;
          pass_r <= 1'b0;
          out_r  <= out_init;
          if (dscs_pkg::op_t'(in_data.opcode) == dscs_pkg::OP_WRITE) begin
            slot_r <= wr_target;
          end else if (dscs_pkg::op_t'(in_data.opcode) == dscs_pkg::OP_LOAD) begin
            slot_r <= '0;
          end else begin
            slot_r <= AW'(in_data.opcode[0]);
          end
        end
      end
      dscs_pkg::ST_RD: begin
        hash_r <= dscs_pkg::FNV_BASIS;
        cnt_r  <= '0;
      end
      dscs_pkg::ST_HASH: begin
        // first hash cycle after a read: latch the row
        if (op == dscs_pkg::OP_LOAD && cnt_r == 6'd0 && hash_r == dscs_pkg::FNV_BASIS
            && !hash_done) begin
          rec_r        <= ram_rdata.rec;
          stored_chk_r <= ram_rdata.check;
          hash_r       <= (hash_r ^ {24'd0, dscs_pkg::rec_byte(ram_rdata.rec, 5'd0)})
                          * dscs_pkg::FNV_PRIME;
          cnt_r        <= 6'd1;
        end else if (!hash_done) begin
          hash_r <= hash_step;
          cnt_r  <= cnt_r + 6'd1;
        end
      end
      dscs_pkg::ST_NEXT: begin
        if (!pass_r) begin
          v0_r   <= slot_good;
          rec0_r <= rec_r;
          pass_r <= 1'b1;
          slot_r <= ~slot_r;
        end else begin
          // pick the newer valid slot; slot 1 wins if slot 0 is invalid or on a strictly higher gen
          if (slot_good && (!v0_r || rec_r.gen > rec0_r.gen)) begin
            out_r <= {1'b1, rec_r};
          end else if (v0_r) begin
            out_r <= {1'b1, rec0_r};
          end
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ----- sv/dscs_ram.sv -----
// Generic single-port RAM with registered read.
// No package dependency.
`default_nettype none
module dscs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire
